// ===== rtl/rfb_client_message_deframer_defines.svh =====
// ---------------------------------------------------------------------------
// RFB client message deframer: shared assertion macros
// Simple implication checks, clocked and reset-qualified.
// ---------------------------------------------------------------------------
`ifndef RFB_CLIENT_MESSAGE_DEFRAMER_DEFINES_SVH
`define RFB_CLIENT_MESSAGE_DEFRAMER_DEFINES_SVH

// same-cycle implication
`define RFBD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rfbd check failed");

// next-cycle implication
`define RFBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rfbd check failed");

`endif

// ===== rtl/rfbd_pkg.sv =====
// ---------------------------------------------------------------------------
// rfbd_pkg
// Codes, lengths and state types of the RFB client message deframer.
// ---------------------------------------------------------------------------
package rfbd_pkg;

   // parser phases
   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_BODY = 3'd1;
   localparam logic [2:0] PH_PAD  = 3'd2;
   localparam logic [2:0] PH_LEN  = 3'd3;
   localparam logic [2:0] PH_HALT = 3'd4;

   // message kinds reported on the result channel
   localparam logic [2:0] KIND_PIXFMT  = 3'd0;
   localparam logic [2:0] KIND_ENC     = 3'd1;
   localparam logic [2:0] KIND_UPDATE  = 3'd2;
   localparam logic [2:0] KIND_KEY     = 3'd3;
   localparam logic [2:0] KIND_POINTER = 3'd4;
   localparam logic [2:0] KIND_CUT     = 3'd5;

   // type bytes on the wire
   localparam logic [7:0] TYPE_PIXFMT  = 8'd0;
   localparam logic [7:0] TYPE_ENC     = 8'd2;
   localparam logic [7:0] TYPE_UPDATE  = 8'd3;
   localparam logic [7:0] TYPE_KEY     = 8'd4;
   localparam logic [7:0] TYPE_POINTER = 8'd5;
   localparam logic [7:0] TYPE_CUT     = 8'd6;

   // body and header lengths
   localparam logic [31:0] LEN_PIXFMT  = 32'd19;
   localparam logic [31:0] LEN_UPDATE  = 32'd9;
   localparam logic [31:0] LEN_KEY     = 32'd7;
   localparam logic [31:0] LEN_POINTER = 32'd5;
   localparam logic [31:0] ENC_PAD     = 32'd1;
   localparam logic [31:0] CUT_PAD     = 32'd3;
   localparam logic [2:0]  ENC_HDR     = 3'd2;
   localparam logic [2:0]  CUT_HDR     = 3'd4;

   // status codes
   localparam logic STAT_DONE  = 1'b0;
   localparam logic STAT_ERROR = 1'b1;

   typedef struct packed {
      logic [2:0]  phase;
      logic [2:0]  current_kind;
      logic [31:0] bytes_left;
      logic [31:0] length_accum;
      logic [2:0]  header_index;
      logic [1:0]  update_count;
   } parse_state_type;

   typedef struct packed {
      logic [2:0] msg_kind;
      logic       status;
      logic [7:0] bad_type;
      logic [1:0] fill_index;
   } result_type;

endpackage

// ===== rtl/rfbd_step.sv =====
// ---------------------------------------------------------------------------
// rfbd_step
// Next-state and result logic of the deframer for one received byte.
// ---------------------------------------------------------------------------
module rfbd_step (
   input  rfbd_pkg::parse_state_type state_cur,
   input  logic [7:0]                data_byte,
   input  logic                      new_connection,
   output rfbd_pkg::parse_state_type state_nxt,
   output logic                      res_valid,
   output rfbd_pkg::result_type      res
);
   import rfbd_pkg::*;

   parse_state_type work;
   logic            finish;
   logic [2:0]      need;
   logic [31:0]     total;

   always_comb begin
      // restart the parser on a new connection, keep the fill phase
      work = state_cur;
      if (new_connection) begin
         work.phase        = PH_IDLE;
         work.current_kind = KIND_PIXFMT;
         work.bytes_left   = '0;
         work.length_accum = '0;
         work.header_index = '0;
      end

      finish    = 1'b0;
      res_valid = 1'b0;
      res       = '0;
      need      = CUT_HDR;
      total     = '0;

      unique case (work.phase)
         PH_IDLE: begin
            unique case (data_byte)
               TYPE_PIXFMT: begin
                  work.current_kind = KIND_PIXFMT;
                  work.phase        = PH_BODY;
                  work.bytes_left   = LEN_PIXFMT;
               end
               TYPE_UPDATE: begin
                  work.current_kind = KIND_UPDATE;
                  work.phase        = PH_BODY;
                  work.bytes_left   = LEN_UPDATE;
               end
               TYPE_KEY: begin
                  work.current_kind = KIND_KEY;
                  work.phase        = PH_BODY;
                  work.bytes_left   = LEN_KEY;
               end
               TYPE_POINTER: begin
                  work.current_kind = KIND_POINTER;
                  work.phase        = PH_BODY;
                  work.bytes_left   = LEN_POINTER;
               end
               TYPE_ENC: begin
                  work.current_kind = KIND_ENC;
                  work.phase        = PH_PAD;
                  work.bytes_left   = ENC_PAD;
               end
               TYPE_CUT: begin
                  work.current_kind = KIND_CUT;
                  work.phase        = PH_PAD;
                  work.bytes_left   = CUT_PAD;
               end
               default: begin
                  // unknown type: report it and halt until a new connection
                  work.phase   = PH_HALT;
                  res_valid    = 1'b1;
                  res.status   = STAT_ERROR;
                  res.bad_type = data_byte;
               end
            endcase
         end
         PH_BODY: begin
            if (work.bytes_left != '0) begin
               work.bytes_left = work.bytes_left - 32'd1;
            end
            if (work.bytes_left == '0) begin
               finish = 1'b1;
            end
         end
         PH_PAD: begin
            if (work.bytes_left != '0) begin
               work.bytes_left = work.bytes_left - 32'd1;
            end
            if (work.bytes_left == '0) begin
               work.phase        = PH_LEN;
               work.header_index = '0;
               work.length_accum = '0;
            end
         end
         PH_LEN: begin
            // shift in the big-endian count or length
            work.length_accum = {work.length_accum[23:0], data_byte};
            work.header_index = work.header_index + 3'd1;
            need = (work.current_kind == KIND_ENC) ? ENC_HDR : CUT_HDR;
            if (work.header_index >= need) begin
               total = (work.current_kind == KIND_ENC)
                     ? {14'd0, work.length_accum[15:0], 2'b00}
                     : work.length_accum;
               work.header_index = '0;
               if (total == '0) begin
                  finish = 1'b1;
               end else begin
                  work.phase      = PH_BODY;
                  work.bytes_left = total;
               end
            end
         end
         default: begin
            // halted or unused phase: drop the byte
         end
      endcase

      // complete the message and advance the fill phase on update requests
      if (finish) begin
         res_valid    = 1'b1;
         res.msg_kind = work.current_kind;
         res.status   = STAT_DONE;
         if (work.current_kind == KIND_UPDATE) begin
            res.fill_index    = work.update_count;
            work.update_count = work.update_count + 2'd1;
         end
         work.phase        = PH_IDLE;
         work.current_kind = KIND_PIXFMT;
         work.bytes_left   = '0;
         work.length_accum = '0;
         work.header_index = '0;
      end

      state_nxt = work;
   end

endmodule

// ===== rtl/rfb_client_message_deframer.sv =====
// Path: an accepted byte is held in the input register; its result is then registered in the result register.
// Throughput: one byte per cycle; the input register stalls the sender only while it
// holds a byte and the held result is stalled.
// Reset: synchronous, active high; clears the parser state, fill phase and
// both valid flags.
// ---------------------------------------------------------------------------
// rfb_client_message_deframer
// Splits the client byte stream of an RFB session into messages and reports
// the kind of each completed message, or an unknown type byte.
// ---------------------------------------------------------------------------
`include "rfb_client_message_deframer_defines.svh"

module rfb_client_message_deframer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_new_connection,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_msg_kind,
   output logic       rsp_status,
   output logic [7:0] rsp_bad_type,
   output logic [1:0] rsp_fill_index
);
   import rfbd_pkg::*;

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff, in_byte_in;
   logic            in_newc_ff, in_newc_in;
   parse_state_type state_ff, state_in;
   logic            out_valid_ff, out_valid_in;
   result_type      out_res_ff, out_res_in;

   parse_state_type step_state;
   logic            step_valid;
   result_type      step_res;
   logic            out_free;
   logic            advance;
   logic            req_take;
   logic            bad_type_unknown;

   // move the held item forward when the result register can take it
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   rfbd_step u_step (
      .state_cur      (state_ff),
      .data_byte      (in_byte_ff),
      .new_connection (in_newc_ff),
      .state_nxt      (step_state),
      .res_valid      (step_valid),
      .res            (step_res)
   );

   // next values of the input register, parser state and result register
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      in_newc_in   = in_newc_ff;
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         if (req_take) begin
            in_byte_in = req_data_byte;
            in_newc_in = req_new_connection;
         end
      end
      if (out_free) begin
         out_valid_in = advance && step_valid;
         if (advance && step_valid) begin
            out_res_in = step_res;
         end
      end
      if (advance) begin
         state_in = step_state;
      end
   end

   // hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // hold payload
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_newc_ff <= in_newc_in;
      out_res_ff <= out_res_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_msg_kind   = out_res_ff.msg_kind;
   assign rsp_status     = out_res_ff.status;
   assign rsp_bad_type   = out_res_ff.bad_type;
   assign rsp_fill_index = out_res_ff.fill_index;

   // a type byte outside the known set
   assign bad_type_unknown = (rsp_bad_type != TYPE_PIXFMT)
                          && ((rsp_bad_type < TYPE_ENC) || (rsp_bad_type > TYPE_CUT));

   // an error carries a type byte outside the known set
   `RFBD_ASSERT_SAME(a_err_type, clock, reset, rsp_valid && rsp_status == STAT_ERROR, bad_type_unknown && rsp_msg_kind == KIND_PIXFMT)
   // only update requests carry a fill phase
   `RFBD_ASSERT_SAME(a_fill_kind, clock, reset, rsp_valid && rsp_fill_index != 2'd0, rsp_msg_kind == KIND_UPDATE)
   // a stall toward the sender means an item is held
   `RFBD_ASSERT_SAME(a_stall_held, clock, reset, req_stall, in_valid_ff && out_valid_ff)
   // a halted parser gives no result for a byte of the same connection
   `RFBD_ASSERT_NEXT(a_halt_quiet, clock, reset, advance && state_ff.phase == PH_HALT && !in_newc_ff, !rsp_valid)

endmodule

// ===== dv/rfbd_result_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rfbd_result_checker
// Watches both channels of the RFB client message deframer, tracks the
// parser in step with every accepted byte and checks each reported message
// against the oldest report due.
// ---------------------------------------------------------------------------
module rfbd_result_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_new_connection,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [2:0] rsp_msg_kind,
   input  logic       rsp_status,
   input  logic [7:0] rsp_bad_type,
   input  logic [1:0] rsp_fill_index,
   output int         fail_count,
   output int         pending
);
   import rfbd_pkg::*;

   // parser state as seen from the byte stream
   logic [2:0]  parse_phase;
   logic [2:0]  open_kind;
   logic [31:0] skip_count;
   logic [31:0] len_build;
   logic [2:0]  hdr_count;
   logic [1:0]  fill_phase;

   // message reports still to arrive, oldest first
   result_type reports_due[$];

   // drop the message in progress; the fill phase survives
   function automatic void clear_message();
      parse_phase = PH_IDLE;
      open_kind   = KIND_PIXFMT;
      skip_count  = '0;
      len_build   = '0;
      hdr_count   = '0;
   endfunction

   // report the open message and return to the type byte
   function automatic bit close_message(output result_type res);
      res            = '0;
      res.msg_kind   = open_kind;
      res.status     = STAT_DONE;
      if (open_kind == KIND_UPDATE) begin
         res.fill_index = fill_phase;
         fill_phase     = fill_phase + 2'd1;
      end
      clear_message();
      return 1'b1;
   endfunction

   // advance the parser by one byte; returns 1 when a report is due
   function automatic bit advance_parser(input logic [7:0] b, input logic nc,
                                         output result_type res);
      logic [31:0] total;
      logic [2:0]  need;
      bit          done;
      done  = 1'b0;
      res   = '0;
      total = '0;
      if (nc)
         clear_message();
      case (parse_phase)
         PH_IDLE: begin
            case (b)
               TYPE_PIXFMT: begin
                  open_kind = KIND_PIXFMT;  parse_phase = PH_BODY; skip_count = LEN_PIXFMT;
               end
               TYPE_UPDATE: begin
                  open_kind = KIND_UPDATE;  parse_phase = PH_BODY; skip_count = LEN_UPDATE;
               end
               TYPE_KEY: begin
                  open_kind = KIND_KEY;     parse_phase = PH_BODY; skip_count = LEN_KEY;
               end
               TYPE_POINTER: begin
                  open_kind = KIND_POINTER; parse_phase = PH_BODY; skip_count = LEN_POINTER;
               end
               TYPE_ENC: begin
                  open_kind = KIND_ENC;     parse_phase = PH_PAD;  skip_count = ENC_PAD;
               end
               TYPE_CUT: begin
                  open_kind = KIND_CUT;     parse_phase = PH_PAD;  skip_count = CUT_PAD;
               end
               default: begin
                  // unknown type: report once, then halt until a new connection
                  parse_phase  = PH_HALT;
                  res.status   = STAT_ERROR;
                  res.bad_type = b;
                  done         = 1'b1;
               end
            endcase
         end
         PH_BODY: begin
            if (skip_count != 0)
               skip_count = skip_count - 32'd1;
            if (skip_count == 0)
               done = close_message(res);
         end
         PH_PAD: begin
            if (skip_count != 0)
               skip_count = skip_count - 32'd1;
            if (skip_count == 0) begin
               parse_phase = PH_LEN;
               hdr_count   = '0;
               len_build   = '0;
            end
         end
         PH_LEN: begin
            // build the big-endian count or length
            len_build = {len_build[23:0], b};
            hdr_count = hdr_count + 3'd1;
            need      = (open_kind == KIND_ENC) ? ENC_HDR : CUT_HDR;
            if (hdr_count >= need) begin
               total     = (open_kind == KIND_ENC) ? {14'd0, len_build[15:0], 2'b00}
                                                   : len_build;
               hdr_count = '0;
               if (total == 0)
                  done = close_message(res);
               else begin
                  parse_phase = PH_BODY;
                  skip_count  = total;
               end
            end
         end
         default: ;
      endcase
      return done;
   endfunction

   // check reports, then track the accepted byte
   always @(posedge clock) begin
      result_type want;
      result_type next_report;
      if (reset) begin
         clear_message();
         fill_phase = '0;
         reports_due.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (reports_due.size() == 0) begin
               $error("report with none due: msg_kind %0d status %0d bad_type %0d fill %0d",
                      rsp_msg_kind, rsp_status, rsp_bad_type, rsp_fill_index);
               fail_count++;
            end else begin
               want = reports_due.pop_front();
               if (rsp_msg_kind !== want.msg_kind) begin
                  $error("msg_kind: expected %0d, got %0d", want.msg_kind, rsp_msg_kind);
                  fail_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_bad_type !== want.bad_type) begin
                  $error("bad_type: expected %0d, got %0d", want.bad_type, rsp_bad_type);
                  fail_count++;
               end
               if (rsp_fill_index !== want.fill_index) begin
                  $error("fill_index: expected %0d, got %0d", want.fill_index,
                         rsp_fill_index);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (advance_parser(req_data_byte, req_new_connection, next_report))
               reports_due.push_back(next_report);
         end
      end
      pending <= reports_due.size();
   end

endmodule

// ===== dv/tb_rfb_client_message_deframer.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_rfb_client_message_deframer
// Feeds the deframer a client byte stream: a directed run through every
// message type, empty and cut-short largest bodies, unknown types, restarts, then
// mostly well-formed random messages mixed with aborted ones and noise.
// Both sides idle at random; the checker beside the block does the scoring.
// ---------------------------------------------------------------------------
module tb_rfb_client_message_deframer;
   import rfbd_pkg::*;

   // type bytes the block does not support
   localparam logic [7:0]  TYPE_COLOUR_MAP   = 8'd1;
   localparam logic [7:0]  TYPE_FIRST_UNUSED = 8'd7;
   localparam logic [7:0]  TYPE_LAST_UNUSED  = 8'hFF;
   localparam int unsigned WHOLE_MSG         = 32'hFFFF_FFFF;
   localparam int          RANDOM_BYTES      = 770;
   localparam int          IDLE_PCT          = 19;
   localparam int          QUIET_LIMIT       = 2000;
   localparam int          DRAIN_CYCLES      = 8;

   logic       clock              = 1'b0;
   logic       reset              = 1'b1;
   logic       req_valid          = 1'b0;
   logic [7:0] req_data_byte      = '0;
   logic       req_new_connection = 1'b0;
   logic       rsp_stall          = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   logic [2:0] rsp_msg_kind;
   logic       rsp_status;
   logic [7:0] rsp_bad_type;
   logic [1:0] rsp_fill_index;

   int fail_count;
   int pending;
   int bytes_sent   = 0;
   int quiet_cycles = 0;
   bit idle_on      = 1'b1;

   rfb_client_message_deframer i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_new_connection (req_new_connection),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_msg_kind       (rsp_msg_kind),
      .rsp_status         (rsp_status),
      .rsp_bad_type       (rsp_bad_type),
      .rsp_fill_index     (rsp_fill_index)
   );

   rfbd_result_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_new_connection (req_new_connection),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_msg_kind       (rsp_msg_kind),
      .rsp_status         (rsp_status),
      .rsp_bad_type       (rsp_bad_type),
      .rsp_fill_index     (rsp_fill_index),
      .fail_count         (fail_count),
      .pending            (pending)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // stall the result side at random
   always @(posedge clock) begin
      rsp_stall <= idle_on && ($urandom_range(0, 99) < IDLE_PCT);
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_rfb_client_message_deframer NOT OK");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   // offer one byte, with random idle cycles ahead of it, and hold until taken
   task automatic send_byte(input logic [7:0] b, input logic nc, input bit counted);
      while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_data_byte      <= b;
      req_new_connection <= nc;
      do @(posedge clock); while (req_stall);
      if (counted)
         bytes_sent++;
   endtask

   // send a message with random content, stopping after cut_at bytes
   task automatic send_msg(input logic [7:0] type_b, input logic [31:0] size,
                           input logic nc, input int unsigned cut_at);
      logic [7:0]  head[$];
      logic [31:0] body_n;
      logic [31:0] k;
      int unsigned sent;
      head.push_back(type_b);
      case (type_b)
         TYPE_PIXFMT:  body_n = LEN_PIXFMT;
         TYPE_UPDATE:  body_n = LEN_UPDATE;
         TYPE_KEY:     body_n = LEN_KEY;
         TYPE_POINTER: body_n = LEN_POINTER;
         TYPE_ENC: begin
            head.push_back(8'($urandom));
            head.push_back(size[15:8]);
            head.push_back(size[7:0]);
            body_n = {14'd0, size[15:0], 2'b00};
         end
         TYPE_CUT: begin
            repeat (3) head.push_back(8'($urandom));
            head.push_back(size[31:24]);
            head.push_back(size[23:16]);
            head.push_back(size[15:8]);
            head.push_back(size[7:0]);
            body_n = size;
         end
         default: body_n = '0;
      endcase
      sent = 0;
      foreach (head[i]) begin
         if (sent < cut_at) begin
            send_byte(head[i], (i == 0) ? nc : 1'b0, 1'b1);
            sent++;
         end
      end
      for (k = 0; k < body_n && sent < cut_at; k++) begin
         send_byte(8'($urandom), 1'b0, 1'b1);
         sent++;
      end
   endtask

   // bytes after an unknown type; the block ignores them
   task automatic send_noise(input int n);
      repeat (n) send_byte(8'($urandom), 1'b0, 1'b0);
   endtask

   // hold off the sender until every due report is out
   task automatic drain_reports();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   initial begin
      logic [7:0]  type_b;
      logic [31:0] size;
      bit          restart_due;
      int          start_count;
      int unsigned pick;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: each message type, empty and cut-short largest bodies, errors, restarts
      send_msg(TYPE_PIXFMT,  '0, 1'b1, WHOLE_MSG);
      send_msg(TYPE_UPDATE,  '0, 1'b0, WHOLE_MSG);
      send_msg(TYPE_KEY,     '0, 1'b0, WHOLE_MSG);
      send_msg(TYPE_POINTER, '0, 1'b0, WHOLE_MSG);
      send_msg(TYPE_ENC,     32'd0, 1'b0, WHOLE_MSG);
      send_msg(TYPE_ENC,     32'd3, 1'b0, WHOLE_MSG);
      send_msg(TYPE_CUT,     32'd0, 1'b0, WHOLE_MSG);
      send_msg(TYPE_CUT,     32'd5, 1'b0, WHOLE_MSG);
      send_msg(TYPE_COLOUR_MAP, '0, 1'b0, WHOLE_MSG);
      send_noise(3);
      send_msg(TYPE_LAST_UNUSED, '0, 1'b1, WHOLE_MSG);
      send_noise(2);
      send_msg(TYPE_CUT,     32'hFFFF_FFFF, 1'b1, 9);
      send_msg(TYPE_CUT,     32'h8000_0000, 1'b1, 10);
      send_msg(TYPE_UPDATE,  '0, 1'b1, WHOLE_MSG);
      send_msg(TYPE_ENC,     32'h0000_FFFF, 1'b0, 12);
      drain_reports();

      // random: mostly well-formed messages, some cut short, some unknown types
      start_count = bytes_sent;
      restart_due = 1'b1;
      while (bytes_sent - start_count < RANDOM_BYTES) begin
         idle_on = !((bytes_sent - start_count >= 150) && (bytes_sent - start_count < 400));
         case ($urandom_range(0, 5))
            0:       type_b = TYPE_PIXFMT;
            1:       type_b = TYPE_ENC;
            2:       type_b = TYPE_UPDATE;
            3:       type_b = TYPE_KEY;
            4:       type_b = TYPE_POINTER;
            default: type_b = TYPE_CUT;
         endcase
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            size = (type_b == TYPE_ENC) ? 32'($urandom_range(0, 6))
                                        : 32'($urandom_range(0, 24));
            send_msg(type_b, size, restart_due || ($urandom_range(0, 3) == 0), WHOLE_MSG);
            restart_due = 1'b0;
         end else if (pick < 84) begin
            // cut short; usually the next message starts a new connection
            size = (type_b == TYPE_ENC) ? 32'($urandom_range(0, 65535)) : $urandom;
            send_msg(type_b, size, restart_due, $urandom_range(1, 12));
            restart_due = ($urandom_range(0, 3) != 0);
         end else if (pick < 95) begin
            type_b = ($urandom_range(0, 3) == 0) ? TYPE_COLOUR_MAP
                     : 8'($urandom_range(TYPE_FIRST_UNUSED, TYPE_LAST_UNUSED));
            send_msg(type_b, '0, restart_due || ($urandom_range(0, 1) == 0), WHOLE_MSG);
            send_noise($urandom_range(0, 6));
            restart_due = 1'b1;
         end else
            drain_reports();
      end
      idle_on = 1'b1;

      drain_reports();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("tb_rfb_client_message_deframer OK");
      else
         $display("tb_rfb_client_message_deframer NOT OK");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rfbd_pkg.sv
rtl/rfbd_step.sv
rtl/rfb_client_message_deframer.sv
dv/rfbd_result_checker.sv
dv/tb_rfb_client_message_deframer.sv
